FILE: rtl/assert_macros.svh
// Assertion macros for the RTL of the buddy tree allocator.
// Needs signals clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define BTA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define BTA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/bta_pkg.sv
// Package of the buddy tree allocator: types, codes and default geometry.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bta_pkg;

  // default heap 1 MiB, minimum block 64 bytes
  localparam int HEAP_LOG_DEF = 20;
  localparam int MIN_LOG_DEF  = 6;

  localparam int FLAG_W = 2;
  localparam logic [FLAG_W-1:0] FLAG_FREE  = 2'b00;
  localparam logic [FLAG_W-1:0] FLAG_ALLOC = 2'b01;
  localparam logic [FLAG_W-1:0] FLAG_SPLIT = 2'b11;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic REG_HEAP_BASE  = 1'b0;
  localparam logic REG_HEAP_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOT_FND  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SIZE,
    S_A_EVAL,
    S_A_FAIL,
    S_A_MARK,
    S_F_CHK,
    S_F_EVAL,
    S_F_MERGE,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/bta_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module bta_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 32767
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/buddy_tree_allocator_core.sv
// Buddy tree allocator core: request FSM, config registers, node flag RAM.
// Depends on bta_pkg, bta_ram and assert_macros.svh.
//
// Use:
//  - in_*: request stream. in_tuser[0] is the kind (0 allocate, 1 free);
//    in_tdata carries the size (bits 31:0) and the address to free (63:32).
//  - out_*: one response per request, in order. out_tdata is the block
//    address (0 on failure and on every free), out_tuser the status
//    (0 ok, 1 no space / too large, 2 outside heap, 3 no block found).
//  - cfg_*: write-only port, heap_base at index 0 and heap_limit at 1;
//    write only while no request is in flight.
//  - Node flags live in one RAM of 2**(HEAP_LOG-MIN_LOG+1)-1 entries.
//    After reset a clearing pass writes one entry a cycle; in_tready stays
//    low until it ends.
//  - An allocate steps the size class up (at most HEAP_LOG-MIN_LOG+1 size
//    steps), visits nodes in a depth-first walk, steps back up, marks each
//    ancestor split and then loads the response; a free checks the address,
//    descends one tree level at a time and examines each buddy on the way
//    up, or goes straight to the response when the address check rejects it.
//    Each walk step waits on the registered RAM read. One request is
//    handled at a time; the next is taken the cycle after the response loads.
//  - The response sits in an output register; a new request is taken
//    while it waits. A stalled receiver holds the core in its last state.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module buddy_tree_allocator_core #(
  parameter int HEAP_LOG = bta_pkg::HEAP_LOG_DEF,
  parameter int MIN_LOG  = bta_pkg::MIN_LOG_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // req_size[31:0], free_address[63:32]
  input  wire logic [0:0]  in_tuser,   // req_type[0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata,  // block_address[31:0]
  output logic      [1:0]  out_tuser,  // status[1:0]
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [31:0] cfg_wdata
);

  localparam int LEAF_LOG   = HEAP_LOG - MIN_LOG;
  localparam int IDX_W      = LEAF_LOG + 1;
  localparam int NODE_COUNT = (2 ** IDX_W) - 1;
  localparam int LVL_W      = (LEAF_LOG > 0) ? $clog2(LEAF_LOG + 1) : 1;
  localparam int LOG_W      = $clog2(HEAP_LOG + 1);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NODE_COUNT - 1);
  localparam logic [LVL_W-1:0] LVL_LEAF = LVL_W'(LEAF_LOG);
  localparam logic [LOG_W-1:0] LOG_MIN  = LOG_W'(MIN_LOG);
  localparam logic [LOG_W-1:0] LOG_HEAP = LOG_W'(HEAP_LOG);

  // registers
  bta_pkg::state_t            state_r, state_nxt;
  logic [IDX_W-1:0]           idx_r, idx_nxt;
  logic [LVL_W-1:0]           lvl_r, lvl_nxt;
  logic [LVL_W-1:0]           want_lvl_r, want_lvl_nxt;
  logic [LOG_W-1:0]           wl_r, wl_nxt;
  logic [HEAP_LOG-1:0]        off_r, off_nxt;
  logic [31:0]                size_r, size_nxt;
  logic [31:0]                faddr_r, faddr_nxt;
  logic                       kind_r, kind_nxt;
  bta_pkg::status_t           stat_r, stat_nxt;
  logic                       hit_r, hit_nxt;
  logic [31:0]                base_r, limit_r;
  logic                       out_valid_r, out_valid_nxt;
  logic [31:0]                out_addr_r, out_addr_nxt;
  bta_pkg::status_t           out_stat_r, out_stat_nxt;

  // RAM
  logic                       wr_en;
  logic [IDX_W-1:0]           wr_addr;
  logic [bta_pkg::FLAG_W-1:0] wr_data;
  logic [bta_pkg::FLAG_W-1:0] rd_data;

  bta_ram #(
    .WIDTH (bta_pkg::FLAG_W),
    .DEPTH (NODE_COUNT)
  ) u_flags (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (idx_nxt),   // read data of idx_nxt shows up with idx_r
    .rdata (rd_data)
  );

  // decode of the node just read
  logic             a_take, a_fail, at_root, is_left, out_free;
  logic             f_alloc, sib_used, off_bit, size_fits, in_range, off_beyond;
  logic [IDX_W-1:0] parent, sibling, left_child, pos;
  logic [31:0]      off_free, take_off, pow;

  assign at_root    = (idx_r == '0);
  assign is_left    = idx_r[0];
  assign parent     = (idx_r - IDX_W'(1)) >> 1;
  assign sibling    = is_left ? (idx_r + IDX_W'(1)) : (idx_r - IDX_W'(1));
  assign left_child = idx_r + idx_r + IDX_W'(1);
  assign a_take     = !rd_data[0] && (lvl_r == want_lvl_r);
  assign a_fail     = (rd_data == bta_pkg::FLAG_ALLOC) || (!a_take && lvl_r == want_lvl_r);
  assign f_alloc    = (rd_data == bta_pkg::FLAG_ALLOC);
  assign sib_used   = rd_data[0];
  assign off_bit    = off_r[HEAP_LOG - 1 - int'(lvl_r)];
  assign pos        = idx_r + IDX_W'(1) - (IDX_W'(1) << lvl_r);
  assign take_off   = 32'(pos) << (LOG_HEAP - LOG_W'(lvl_r));
  assign pow        = 32'd1 << wl_r;
  assign size_fits  = (pow >= size_r);
  assign in_range   = (faddr_r >= base_r) && (faddr_r <= limit_r);
  assign off_free   = faddr_r - base_r;
  assign off_beyond = (off_free >> HEAP_LOG) != 32'd0;
  assign out_free   = !out_valid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bta_pkg::S_CLEAR: begin
        if (idx_r == IDX_LAST) state_nxt = bta_pkg::S_IDLE;
      end
      bta_pkg::S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (in_tuser[0] == bta_pkg::REQ_FREE) ? bta_pkg::S_F_CHK : bta_pkg::S_SIZE;
        end
      end
      bta_pkg::S_SIZE: begin
        if (size_fits)             state_nxt = bta_pkg::S_A_EVAL;
        else if (wl_r == LOG_HEAP) state_nxt = bta_pkg::S_DONE;
      end
      bta_pkg::S_A_EVAL: begin
        if (a_take) begin
          state_nxt = at_root ? bta_pkg::S_DONE : bta_pkg::S_A_MARK;
        end else if (a_fail) begin
          if (at_root)       state_nxt = bta_pkg::S_DONE;
          else if (!is_left) state_nxt = bta_pkg::S_A_FAIL;
        end
      end
      bta_pkg::S_A_FAIL: begin
        if (at_root)      state_nxt = bta_pkg::S_DONE;
        else if (is_left) state_nxt = bta_pkg::S_A_EVAL;
      end
      bta_pkg::S_A_MARK: begin
        if (at_root) state_nxt = bta_pkg::S_DONE;
      end
      bta_pkg::S_F_CHK: begin
        state_nxt = (!in_range || off_beyond) ? bta_pkg::S_DONE : bta_pkg::S_F_EVAL;
      end
      bta_pkg::S_F_EVAL: begin
        if (f_alloc)                state_nxt = at_root ? bta_pkg::S_DONE : bta_pkg::S_F_MERGE;
        else if (lvl_r == LVL_LEAF) state_nxt = bta_pkg::S_DONE;
      end
      bta_pkg::S_F_MERGE: begin
        if (sib_used || parent == '0) state_nxt = bta_pkg::S_DONE;
      end
      bta_pkg::S_DONE: begin
        if (out_free) state_nxt = bta_pkg::S_IDLE;
      end
      default: state_nxt = bta_pkg::S_IDLE;
    endcase
  end

  // datapath and RAM writes
  always_comb begin
    idx_nxt       = idx_r;
    lvl_nxt       = lvl_r;
    want_lvl_nxt  = want_lvl_r;
    wl_nxt        = wl_r;
    off_nxt       = off_r;
    size_nxt      = size_r;
    faddr_nxt     = faddr_r;
    kind_nxt      = kind_r;
    stat_nxt      = stat_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_addr_nxt  = out_addr_r;
    out_stat_nxt  = out_stat_r;
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_data       = bta_pkg::FLAG_FREE;
    in_tready     = 1'b0;
    case (state_r)
      bta_pkg::S_CLEAR: begin
        wr_en   = 1'b1;
        idx_nxt = (idx_r == IDX_LAST) ? '0 : idx_r + IDX_W'(1);
      end
      bta_pkg::S_IDLE: begin
        in_tready = 1'b1;
        size_nxt  = in_tdata[31:0];
        faddr_nxt = in_tdata[63:32];
        kind_nxt  = in_tuser[0];
        wl_nxt    = LOG_MIN;
        stat_nxt  = bta_pkg::ST_OK;
        hit_nxt   = 1'b0;
      end
      bta_pkg::S_SIZE: begin
        if (size_fits) begin
          idx_nxt      = '0;
          lvl_nxt      = '0;
          want_lvl_nxt = LVL_W'(LOG_HEAP - wl_r);
        end else if (wl_r == LOG_HEAP) begin
          stat_nxt = bta_pkg::ST_NO_SPACE;
        end else begin
          wl_nxt = wl_r + LOG_W'(1);
        end
      end
      bta_pkg::S_A_EVAL: begin
        if (a_take) begin
          wr_en   = 1'b1;
          wr_data = bta_pkg::FLAG_ALLOC;
          off_nxt = take_off[HEAP_LOG-1:0];
          hit_nxt = 1'b1;
          idx_nxt = parent;
        end else if (a_fail) begin
          if (at_root) begin
            stat_nxt = bta_pkg::ST_NO_SPACE;
          end else if (is_left) begin
            idx_nxt = idx_r + IDX_W'(1);
          end else begin
            idx_nxt = parent;
            lvl_nxt = lvl_r - LVL_W'(1);
          end
        end else begin
          idx_nxt = left_child;
          lvl_nxt = lvl_r + LVL_W'(1);
        end
      end
      bta_pkg::S_A_FAIL: begin
        if (at_root) begin
          stat_nxt = bta_pkg::ST_NO_SPACE;
        end else if (is_left) begin
          idx_nxt = idx_r + IDX_W'(1);
        end else begin
          idx_nxt = parent;
          lvl_nxt = lvl_r - LVL_W'(1);
        end
      end
      bta_pkg::S_A_MARK: begin
        wr_en   = 1'b1;
        wr_data = bta_pkg::FLAG_SPLIT;
        idx_nxt = parent;
      end
      bta_pkg::S_F_CHK: begin
        off_nxt = off_free[HEAP_LOG-1:0];
        idx_nxt = '0;
        lvl_nxt = '0;
        if (!in_range)       stat_nxt = bta_pkg::ST_RANGE;
        else if (off_beyond) stat_nxt = bta_pkg::ST_NOT_FND;
      end
      bta_pkg::S_F_EVAL: begin
        if (f_alloc) begin
          wr_en   = 1'b1;
          idx_nxt = sibling;   // buddy flags decide the merge
        end else if (lvl_r == LVL_LEAF) begin
          stat_nxt = bta_pkg::ST_NOT_FND;
        end else begin
          idx_nxt = left_child + IDX_W'(off_bit);
          lvl_nxt = lvl_r + LVL_W'(1);
        end
      end
      bta_pkg::S_F_MERGE: begin
        if (!sib_used) begin
          wr_en   = 1'b1;
          wr_addr = parent;
          idx_nxt = parent[0] ? (parent + IDX_W'(1)) : (parent - IDX_W'(1));
        end
      end
      bta_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = stat_r;
          out_addr_nxt  = (hit_r && kind_r == bta_pkg::REQ_ALLOC) ?
                          (base_r + 32'(off_r)) : 32'd0;
          idx_nxt       = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bta_pkg::S_CLEAR;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      base_r      <= 32'd0;
      limit_r     <= 32'hFFFF_FFFF;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_addr == bta_pkg::REG_HEAP_BASE)  base_r  <= cfg_wdata;
      if (cfg_we && cfg_addr == bta_pkg::REG_HEAP_LIMIT) limit_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r      <= lvl_nxt;
    want_lvl_r <= want_lvl_nxt;
    wl_r       <= wl_nxt;
    off_r      <= off_nxt;
    size_r     <= size_nxt;
    faddr_r    <= faddr_nxt;
    kind_r     <= kind_nxt;
    stat_r     <= stat_nxt;
    hit_r      <= hit_nxt;
    out_addr_r <= out_addr_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_addr_r;
  assign out_tuser  = out_stat_r;

  // checks
  `BTA_ASSERT(a_walk_depth, (state_r == bta_pkg::S_A_EVAL) |-> (lvl_r <= want_lvl_r), "alloc walk below wanted level")
  `BTA_ASSERT(a_free_depth, (state_r == bta_pkg::S_F_EVAL) |-> (lvl_r <= LVL_LEAF), "free walk below leaves")
  `BTA_ASSERT(a_resp_src, $rose(out_valid_r) |-> $past(state_r == bta_pkg::S_DONE), "response not from done state")
  `BTA_ASSERT(a_idle_quiet, (state_r == bta_pkg::S_IDLE) |-> !wr_en, "flag write while idle")

endmodule
`default_nettype wire
